[hw/rtl/flow_block_averager_top_macros.svh]
// Assertion macros for the flow block averager
`ifndef FLOW_BLOCK_AVERAGER_TOP_MACROS_SVH
`define FLOW_BLOCK_AVERAGER_TOP_MACROS_SVH

// Antecedent implies consequent in the same cycle
`define FBA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle
`define FBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/fba_pkg.sv]
package fba_pkg;

  localparam int MAX_BLOCK_COLS = 64;
  localparam int COL_W          = $clog2(MAX_BLOCK_COLS);
  localparam int SAMPLE_W       = 16;
  localparam int SUM_W          = 32;
  localparam int DEN_W          = 17;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] flow_x;
    logic signed [SAMPLE_W-1:0] flow_y;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] avg_x;
    logic signed [15:0] avg_y;
    logic [5:0]         block_col;
    logic [11:0]        block_row;
    logic               last;
  } out_word_t;

  // divider handshake
  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

  function automatic logic signed [15:0] sat16(input logic neg, input logic [SUM_W-1:0] q);
    logic signed [15:0] r;
    if (!neg) begin
      r = (q > 32'd32767) ? 16'sh7fff : q[15:0];
    end else begin
      r = (q > 32'd32768) ? 16'sh8000 : 16'(-q[15:0]);
    end
    return r;
  endfunction

endpackage

[hw/rtl/fba_ram.sv]
module fba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/fba_div.sv]
module fba_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [fba_pkg::SUM_W-1:0] num,
  input  logic [fba_pkg::DEN_W-1:0] den,
  output logic                     done,
  output logic [fba_pkg::SUM_W-1:0] quo
);
  import fba_pkg::*;

  logic             busy;
  logic [5:0]       step;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dreg;
  logic [DEN_W:0]   shifted;
  logic             fits;

  assign shifted = {rem, quo[SUM_W-1]};
  assign fits    = shifted >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        rem  <= '0;
        quo  <= num;
        dreg <= den;
      end else if (busy) begin
        rem  <= fits ? DEN_W'(shifted - {1'b0, dreg}) : shifted[DEN_W-1:0];
        quo  <= {quo[SUM_W-2:0], fits};
        step <= step + 6'd1;
        if (step == 6'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[hw/rtl/flow_block_averager_top.sv]
// Flow: S_IDLE takes a pixel word and S_ACC adds it to its column sum. After the closing word
// of a block row, the sweep visits all 64 column entries through S_ERD and S_ELD, and for
// each column inside the frame divides (S_EGO, S_EDIV) and outputs (S_EOUT, held by out_stall).
// Input: no new word is taken before the last is summed; input stays stalled for the whole sweep.
// Reset: synchronous; registers take their defaults, then a clearing pass
// zeroes the sum RAM while input stays stalled (configuration writes still taken).
module flow_block_averager_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  fba_pkg::in_word_t             in_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output fba_pkg::out_word_t            out_word,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fba_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fba_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_ERD   = 3'd3;
  localparam logic [2:0] S_ELD   = 3'd4;
  localparam logic [2:0] S_EGO   = 3'd5;
  localparam logic [2:0] S_EDIV  = 3'd6;
  localparam logic [2:0] S_EOUT  = 3'd7;

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(MAX_BLOCK_COLS - 1);

  logic [2:0]  state;
  logic [12:0] frame_width, frame_height;
  logic [7:0]  blk_edge;
  logic [11:0] pixel_col, pixel_row, current_block_row, emit_row;
  logic [7:0]  col_in_block, row_in_block;
  logic [COL_W-1:0] current_block_col, sweep_col;
  logic        beyond;
  in_word_t    sample;
  logic [13:0] start_pos;
  logic [8:0]  rows;
  logic [DEN_W-1:0] cnt;
  logic        last_flag;
  logic        neg_x, neg_y;

  logic [12:0] w_eff, h_eff;
  logic [7:0]  bs_eff;
  logic        row_end, frame_end, blk_end, col_end;
  logic [13:0] rem_w;
  logic [7:0]  cw;
  logic        in_col;

  logic               ram_we, ram_re;
  logic [COL_W-1:0]   ram_waddr, ram_raddr;
  logic [2*SUM_W-1:0] ram_wdata, ram_rdata;
  logic signed [SUM_W-1:0] rd_x, rd_y;

  div_ctl_t         div_x, div_y;
  logic [SUM_W-1:0] quo_x, quo_y;

  assign w_eff  = (frame_width == '0) ? 13'd1 :
                  (frame_width > 13'd4096) ? 13'd4096 : frame_width;
  assign h_eff  = (frame_height == '0) ? 13'd1 :
                  (frame_height > 13'd4096) ? 13'd4096 : frame_height;
  assign bs_eff = (blk_edge == '0) ? 8'd1 : blk_edge;

  assign row_end   = {1'b0, pixel_col} >= 13'(w_eff - 13'd1);
  assign frame_end = {1'b0, pixel_row} >= 13'(h_eff - 13'd1);
  assign blk_end   = row_in_block >= 8'(bs_eff - 8'd1);
  assign col_end   = col_in_block >= 8'(bs_eff - 8'd1);

  assign in_col = start_pos < {1'b0, w_eff};
  assign rem_w  = 14'({1'b0, w_eff} - start_pos);
  assign cw     = (rem_w > {6'd0, bs_eff}) ? bs_eff : rem_w[7:0];

  assign rd_x = ram_rdata[2*SUM_W-1:SUM_W];
  assign rd_y = ram_rdata[SUM_W-1:0];

  assign in_stall  = state != S_IDLE;
  assign cfg_ready = 1'b1;

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = current_block_col;
    ram_we    = 1'b0;
    ram_waddr = sweep_col;
    ram_wdata = '0;
    case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        ram_re = in_valid;
      end
      S_ACC: begin
        ram_we    = !beyond;
        ram_waddr = current_block_col;
        ram_wdata = {SUM_W'(rd_x + SUM_W'(sample.flow_x)),
                     SUM_W'(rd_y + SUM_W'(sample.flow_y))};
      end
      S_ERD: begin
        ram_re    = 1'b1;
        ram_raddr = sweep_col;
      end
      S_ELD: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  fba_ram #(.WIDTH(2*SUM_W), .DEPTH(MAX_BLOCK_COLS)) u_sums (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  logic [SUM_W-1:0] mag_x, mag_y;

  always_ff @(posedge clk) begin
    if (state == S_ELD) begin
      mag_x <= rd_x[SUM_W-1] ? SUM_W'(-rd_x) : rd_x;
      mag_y <= rd_y[SUM_W-1] ? SUM_W'(-rd_y) : rd_y;
    end
  end

  assign div_x.start = state == S_EGO;
  assign div_y.start = state == S_EGO;

  fba_div u_div_x (
    .clk(clk), .rst(rst), .start(div_x.start), .num(mag_x), .den(cnt),
    .done(div_x.done), .quo(quo_x)
  );

  fba_div u_div_y (
    .clk(clk), .rst(rst), .start(div_y.start), .num(mag_y), .den(cnt),
    .done(div_y.done), .quo(quo_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_CLEAR;
      frame_width       <= 13'd640;
      frame_height      <= 13'd480;
      blk_edge          <= 8'd16;
      pixel_col         <= '0;
      pixel_row         <= '0;
      col_in_block      <= '0;
      row_in_block      <= '0;
      current_block_col <= '0;
      current_block_row <= '0;
      beyond            <= 1'b0;
      sweep_col         <= '0;
      start_pos         <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
          CFG_FRAME_HEIGHT: frame_height <= cfg_data;
          CFG_BLOCK_SIZE:   blk_edge     <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
      case (state)
        S_CLEAR: begin
          if (sweep_col == LAST_COL) begin
            state <= S_IDLE;
          end
          sweep_col <= sweep_col + 1'b1;
        end
        S_IDLE: begin
          if (in_valid) begin
            sample <= in_word;
            state  <= S_ACC;
          end
        end
        S_ACC: begin
          if (row_end) begin
            if (blk_end || frame_end) begin
              rows              <= 9'(row_in_block) + 9'd1;
              emit_row          <= current_block_row;
              row_in_block      <= '0;
              current_block_row <= frame_end ? 12'd0 : current_block_row + 12'd1;
              sweep_col         <= '0;
              start_pos         <= '0;
              state             <= S_ERD;
            end else begin
              row_in_block <= row_in_block + 8'd1;
              state        <= S_IDLE;
            end
            if (frame_end) begin
              pixel_row <= '0;
            end else begin
              pixel_row <= pixel_row + 12'd1;
            end
            pixel_col         <= '0;
            col_in_block      <= '0;
            current_block_col <= '0;
            beyond            <= 1'b0;
          end else begin
            state     <= S_IDLE;
            pixel_col <= pixel_col + 12'd1;
            if (col_end) begin
              col_in_block <= '0;
              if (current_block_col == LAST_COL) begin
                beyond <= 1'b1;
              end else begin
                current_block_col <= current_block_col + 1'b1;
              end
            end else begin
              col_in_block <= col_in_block + 8'd1;
            end
          end
        end
        S_ERD: begin
          state <= S_ELD;
        end
        S_ELD: begin
          neg_x     <= rd_x[SUM_W-1];
          neg_y     <= rd_y[SUM_W-1];
          cnt       <= DEN_W'(cw) * DEN_W'(rows);
          last_flag <= (start_pos + 14'(bs_eff) >= {1'b0, w_eff}) ||
                       (sweep_col == LAST_COL);
          if (in_col) begin
            state <= S_EGO;
          end else if (sweep_col == LAST_COL) begin
            state <= S_IDLE;
          end else begin
            sweep_col <= sweep_col + 1'b1;
            start_pos <= start_pos + 14'(bs_eff);
            state     <= S_ERD;
          end
        end
        S_EGO: begin
          state <= S_EDIV;
        end
        S_EDIV: begin
          if (div_x.done && div_y.done) begin
            out_word.avg_x     <= sat16(neg_x, quo_x);
            out_word.avg_y     <= sat16(neg_y, quo_y);
            out_word.block_col <= 6'(sweep_col);
            out_word.block_row <= emit_row;
            out_word.last      <= last_flag;
            out_valid          <= 1'b1;
            state              <= S_EOUT;
          end
        end
        S_EOUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (sweep_col == LAST_COL) begin
              state <= S_IDLE;
            end else begin
              sweep_col <= sweep_col + 1'b1;
              start_pos <= start_pos + 14'(bs_eff);
              state     <= S_ERD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/fba_checker.sv]
`include "flow_block_averager_top_macros.svh"

module fba_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input fba_pkg::out_word_t out_word
);
  import fba_pkg::*;

  `FBA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `FBA_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_word))
  `FBA_ASSERT_SAME(a_no_in_while_out, out_valid, in_stall)
  `FBA_ASSERT_NEXT(a_in_gap, in_valid && !in_stall, in_stall)

endmodule

bind flow_block_averager_top fba_checker u_fba_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_word (out_word)
);

[tb/sv/flow_block_averager_top_tb.sv]
`timescale 1ns / 1ps

module flow_block_averager_top_tb;
  import fba_pkg::*;

  localparam int SETTLE = 300;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD = 400;

  class flow_avg_board;
    out_word_t want_q[$];
    int errors;
    logic [12:0] fw, fh;
    logic [7:0] bsz;
    longint acc_x[MAX_BLOCK_COLS], acc_y[MAX_BLOCK_COLS];
    int unsigned pcol, prow, cib, bcol, rib, brow;
    bit past_cols;

    function new();
      errors = 0;
      fw = 13'd640;
      fh = 13'd480;
      bsz = 8'd16;
      foreach (acc_x[i]) begin
        acc_x[i] = 0;
        acc_y[i] = 0;
      end
      pcol = 0; prow = 0; cib = 0; bcol = 0; rib = 0; brow = 0;
      past_cols = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_FRAME_WIDTH: fw = d;
        CFG_FRAME_HEIGHT: fh = d;
        CFG_BLOCK_SIZE: bsz = d[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned clamp_dim(int unsigned v);
      if (v == 0) return 1;
      if (v > 4096) return 4096;
      return v;
    endfunction

    function logic [15:0] sat_q88(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    function void note_pixel(in_word_t p);
      int unsigned w, h, b, nbc, rows, cw;
      longint cnt;
      out_word_t r;
      bit fend;
      w = clamp_dim(fw);
      h = clamp_dim(fh);
      b = (bsz == 0) ? 1 : bsz;
      if (!past_cols && bcol < MAX_BLOCK_COLS) begin
        acc_x[bcol] += p.flow_x;
        acc_y[bcol] += p.flow_y;
      end
      if (pcol >= w - 1) begin
        fend = prow >= h - 1;
        if (rib >= b - 1 || fend) begin
          nbc = (w + b - 1) / b;
          if (nbc > MAX_BLOCK_COLS) nbc = MAX_BLOCK_COLS;
          rows = rib + 1;
          for (int unsigned bc = 0; bc < nbc; bc++) begin
            cw = w - bc * b;
            if (cw > b) cw = b;
            cnt = longint'(cw) * longint'(rows);
            r.avg_x = sat_q88(acc_x[bc] / cnt);
            r.avg_y = sat_q88(acc_y[bc] / cnt);
            r.block_col = 6'(bc);
            r.block_row = 12'(brow);
            r.last = (bc + 1 == nbc);
            want_q = {want_q, r};
          end
          foreach (acc_x[i]) begin
            acc_x[i] = 0;
            acc_y[i] = 0;
          end
          rib = 0;
          brow = (brow + 1) & 'hFFF;
        end else begin
          rib = (rib + 1) & 'hFF;
        end
        if (fend) begin
          prow = 0;
          brow = 0;
        end else begin
          prow = (prow + 1) & 'hFFF;
        end
        pcol = 0; cib = 0; bcol = 0;
        past_cols = 0;
      end else begin
        pcol = (pcol + 1) & 'hFFF;
        if (cib >= b - 1) begin
          cib = 0;
          if (bcol + 1 >= MAX_BLOCK_COLS) past_cols = 1;
          else bcol++;
        end else begin
          cib = (cib + 1) & 'hFF;
        end
      end
    endfunction

    function void check_avg(out_word_t got);
      out_word_t e;
      if (want_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word %p", $time, got);
        return;
      end
      e = want_q.pop_front();
      if (got.avg_x !== e.avg_x || got.avg_y !== e.avg_y || got.block_col !== e.block_col ||
          got.block_row !== e.block_row || got.last !== e.last) begin
        errors++;
        $display("%0t: mismatch expected %p actual %p", $time, e, got);
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  in_word_t in_word;
  out_word_t out_word;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  flow_avg_board board;
  bit calm;
  int hold_ask, hold_seen;
  int idle_cycles;

  flow_block_averager_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int wait_left, hold_left;
    wait_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (out_valid && !out_stall) begin
          board.check_avg(out_word);
          wait_left = calm ? 0 : $urandom_range(0, 5);
        end
        if (hold_ask != hold_seen) begin
          hold_seen = hold_ask;
          hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_stall <= 1'b1;
        end else if (wait_left > 0) begin
          wait_left--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("flow_block_averager_top_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_pixel(in_word_t p);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= p;
    do @(posedge clk); while (in_stall);
    board.note_pixel(p);
  endtask

  // leaves cfg_valid high; the caller drops it after its last write
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, d);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_geometry(int w, int h, int b);
    drain();
    write_cfg(CFG_FRAME_WIDTH, 13'(w));
    write_cfg(CFG_FRAME_HEIGHT, 13'(h));
    write_cfg(CFG_BLOCK_SIZE, 13'(b));
    cfg_valid <= 1'b0;
  endtask

  function automatic in_word_t rand_pixel();
    in_word_t p;
    case ($urandom_range(0, 7))
      0: p = {16'sh7fff, 16'sh8000};
      1: p = {16'sh8000, 16'sh7fff};
      default: p = $urandom;
    endcase
    return p;
  endfunction

  // send n pixels; optionally pause for all results or ask for a long hold-off midway
  task automatic run_pixels(int n, bit pause_mid, bit hold_mid);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) begin
        if (pause_mid) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (board.pending() != 0);
        end
        if (hold_mid) hold_ask++;
      end
      send_pixel(rand_pixel());
    end
  endtask

  initial begin
    in_word_t edge_vals[$];
    int sent, w, h, b, n;
    board = new();
    calm = 0;
    hold_ask = 0;
    hold_seen = 0;
    idle_cycles = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_FRAME_WIDTH;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset geometry, then a width cut mid-row
    for (int i = 0; i < 3; i++) send_pixel({16'sh7fff, 16'sh8000});
    set_geometry(1, 1, 1);
    edge_vals = '{{16'sh7fff, 16'sh8000}, {16'sh8000, 16'sh7fff}, {16'sh0000, 16'shffff},
                  {16'shffff, 16'sh0001}, {16'sh5555, 16'shaaaa}, {16'shaaaa, 16'sh5555},
                  {16'sh0001, 16'sh0000}};
    foreach (edge_vals[i]) send_pixel(edge_vals[i]);
    set_geometry(0, 0, 0);
    for (int i = 0; i < 3; i++) send_pixel(rand_pixel());
    set_geometry(3, 2, 2);
    for (int i = 0; i < 6; i++) send_pixel({16'sh8000, 16'sh8000});

    // too many block columns, with a long output hold-off
    set_geometry(100, 3, 1);
    run_pixels(150, 1'b0, 1'b1);
    // widest and tallest frame registers, left mid-row
    set_geometry(8191, 8191, 255);
    run_pixels(40, 1'b0, 1'b0);

    sent = 0;
    while (sent < 280) begin
      w = $urandom_range(1, 20);
      h = $urandom_range(1, 8);
      b = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 10);
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, w * h) : w * h;
      calm = ($urandom_range(0, 3) == 0);
      set_geometry(w, h, b);
      run_pixels(n, sent == 0, 1'b0);
      sent += n;
    end
    calm = 0;

    drain();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("flow_block_averager_top_tb OK");
    end else begin
      $display("flow_block_averager_top_tb NOT OK");
    end
    $finish;
  end

endmodule
